// ===== sv/titp_pkg.sv =====
package titp_pkg;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NUM,
		PH_PUNCT1,
		PH_WORD,
		PH_SPACE1,
		PH_PUNCT2,
		PH_FAIL
	} phase_t;

	localparam int UnitCount = 10;
	localparam int NameMax = 12;

	typedef logic [UnitCount-1:0] unit_mask_t;

	typedef struct packed {
		phase_t            phase;
		logic [31:0]       number_value;
		logic [31:0]       interval_sum;
		logic              units_ok;
		unit_mask_t        word_match;
		logic [3:0]        word_length;
	} parse_state_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] total_msecs;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:        PH_LEAD,
		number_value: 32'd0,
		interval_sum: 32'd0,
		units_ok:     1'b1,
		word_match:   {UnitCount{1'b1}},
		word_length:  4'd0
	};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [31:0] MS_PER_SEC  = 32'd1000;
	localparam logic [31:0] MS_PER_MIN  = 32'd60000;
	localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
	localparam logic [31:0] MS_PER_DAY  = 32'd86400000;
	localparam logic [31:0] DAY_LIMIT   = 32'd24;

	// Names are right-justified in the vector, so the first letter is the top byte in use.
	localparam logic [8*NameMax-1:0] UNIT_NAMES [UnitCount] = '{
		"days", "hours", "minutes", "mins", "seconds", "secs",
		"milliseconds", "millisecs", "mseconds", "msecs"
	};
	localparam logic [3:0] UNIT_LEN [UnitCount] = '{
		4'd4, 4'd5, 4'd7, 4'd4, 4'd7, 4'd4, 4'd12, 4'd9, 4'd8, 4'd5
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	// Letter at position idx of unit name k, or zero past the end of the name.
	function automatic logic [7:0] name_char(input int k, input logic [3:0] idx);
		logic [8*NameMax-1:0] word;
		int pos;
		word = UNIT_NAMES[k];
		pos = 8 * (int'(UNIT_LEN[k]) - 1 - int'(idx));
		if (idx >= UNIT_LEN[k]) begin
			return 8'd0;
		end
		return word[pos +: 8];
	endfunction

endpackage

// ===== sv/titp_step.sv =====
module titp_step import titp_pkg::*; (
	input  logic [7:0]   ch,
	input  parse_state_t cur,
	output parse_state_t nxt,
	output result_t      res
);

	logic [7:0]  lc;
	logic [31:0] scale;
	logic [31:0] prod;
	logic [31:0] sum_plus;
	logic [35:0] num_x10;
	logic        num_ovf;
	logic        unit_none;
	logic        day_fail;
	logic        done;

	assign lc = ch | 8'h20;

	// A unit is applied only from the word phase; every other product is a trailing seconds count.
	always_comb begin
		scale = MS_PER_SEC;
		if (cur.phase == PH_WORD) begin
			if (cur.word_match[0]) begin
				scale = MS_PER_DAY;
			end else if (cur.word_match[1]) begin
				scale = MS_PER_HOUR;
			end else if (cur.word_match[2] || cur.word_match[3]) begin
				scale = MS_PER_MIN;
			end else if (cur.word_match[4] || cur.word_match[5]) begin
				scale = MS_PER_SEC;
			end else begin
				scale = 32'd1;
			end
		end
	end

	assign prod      = cur.number_value * scale;
	assign sum_plus  = cur.interval_sum + prod;
	assign num_x10   = {4'd0, cur.number_value} * 36'd10 + {32'd0, ch[3:0]};
	assign num_ovf   = |num_x10[35:32];
	assign unit_none = (cur.word_match == '0);
	assign day_fail  = cur.word_match[0] && (cur.number_value > DAY_LIMIT);

	// Phases fall through into each other within one byte, as the parse rules demand.
	always_comb begin : next_state
		nxt  = cur;
		done = 1'b0;
		if (nxt.phase == PH_LEAD) begin
			if (is_space(ch)) begin
				done = 1'b1;
			end else if (is_digit(ch)) begin
				nxt.number_value = {28'd0, ch[3:0]};
				nxt.phase = PH_NUM;
				done = 1'b1;
			end else begin
				nxt.phase = PH_FAIL;
			end
		end
		if (!done && nxt.phase == PH_NUM) begin
			if (is_digit(ch)) begin
				if (num_ovf) begin
					nxt.phase = PH_FAIL;
				end else begin
					nxt.number_value = num_x10[31:0];
				end
				done = 1'b1;
			end else begin
				nxt.phase = PH_PUNCT1;
			end
		end
		if (!done && nxt.phase == PH_PUNCT1) begin
			if (is_punct(ch) && ch != CH_MINUS) begin
				done = 1'b1;
			end else begin
				nxt.word_length = 4'd0;
				nxt.word_match = '1;
				nxt.phase = is_alpha(ch) ? PH_WORD : PH_SPACE1;
			end
		end
		if (!done && nxt.phase == PH_WORD) begin
			if (is_alpha(ch)) begin
				for (int k = 0; k < UnitCount; k++) begin
					if (name_char(k, nxt.word_length) != lc) begin
						nxt.word_match[k] = 1'b0;
					end
				end
				if (nxt.word_length != 4'hF) begin
					nxt.word_length = nxt.word_length + 4'd1;
				end
				done = 1'b1;
			end else if (unit_none) begin
				nxt.units_ok = 1'b0;
				nxt.phase = PH_SPACE1;
			end else if (day_fail) begin
				nxt.phase = PH_FAIL;
			end else begin
				nxt.interval_sum = sum_plus;
				nxt.phase = PH_SPACE1;
			end
		end
		if (!done && nxt.phase == PH_SPACE1) begin
			if (is_space(ch)) begin
				done = 1'b1;
			end else if (nxt.word_length == 4'd0) begin
				nxt.phase = PH_FAIL;
			end else begin
				nxt.phase = PH_PUNCT2;
			end
		end
		if (!done && nxt.phase == PH_PUNCT2) begin
			if (is_punct(ch) && ch != CH_MINUS) begin
				done = 1'b1;
			end else if (is_digit(ch)) begin
				nxt.number_value = {28'd0, ch[3:0]};
				nxt.phase = PH_NUM;
				done = 1'b1;
			end else begin
				nxt.phase = PH_FAIL;
			end
		end
		if (!done) begin
			nxt.phase = PH_FAIL;
		end
		// The terminator always ends the string and restarts the parser.
		if (ch == CH_NUL) begin
			nxt = STATE_RESET;
		end
	end

	// Result for a terminator arriving in the current phase.
	always_comb begin : result_out
		res.ok = 1'b0;
		res.total_msecs = cur.interval_sum;
		case (cur.phase)
			PH_NUM, PH_PUNCT1: begin
				res.ok = 1'b1;
				res.total_msecs = sum_plus;
			end
			PH_WORD: begin
				if (day_fail) begin
					res.ok = 1'b0;
				end else if (unit_none) begin
					res.ok = 1'b0;
				end else begin
					res.ok = cur.units_ok;
					res.total_msecs = sum_plus;
				end
			end
			PH_SPACE1: begin
				if (cur.word_length == 4'd0) begin
					res.ok = 1'b1;
					res.total_msecs = sum_plus;
				end else begin
					res.ok = cur.units_ok;
				end
			end
			PH_PUNCT2: begin
				res.ok = cur.units_ok;
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/titp_out_reg.sv =====
module titp_out_reg import titp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t d,
	input  logic    stall,
	output logic    valid,
	output result_t q,
	output logic    free
);

	logic    valid_q;
	result_t res_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign q     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

endmodule

// ===== sv/time_interval_text_parser.sv =====
// Parses a zero-terminated ASCII interval string such as "1h 30min" into milliseconds,
// one byte per transaction, and returns one result transaction for each terminating zero
// byte. A byte can be taken in every cycle: it lands in an input register, and from there
// a single parse step updates the parser state and, for a terminator, loads the result
// into the output register that offers it. The output register lets the next string
// stream in while a result waits; only a second terminator arriving while the previous
// result is still stalled holds up the input.
module time_interval_text_parser import titp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  ch,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        ok,
	output logic [31:0] total_msecs
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	parse_state_t state_q;
	parse_state_t state_next;
	result_t      step_res;
	result_t      out_res;
	logic         out_free;
	logic         adv;
	logic         emit;

	assign emit       = (ch_s1 == CH_NUL);
	assign adv        = valid_s1 && (!emit || out_free);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv) begin
			state_q <= state_next;
		end
	end

	titp_step u_step (
		.ch  (ch_s1),
		.cur (state_q),
		.nxt (state_next),
		.res (step_res)
	);

	titp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && emit),
		.d      (step_res),
		.stall  (result_stall),
		.valid  (result_valid),
		.q      (out_res),
		.free   (out_free)
	);

	assign ok          = out_res.ok;
	assign total_msecs = out_res.total_msecs;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |-> out_free)
		else $error("result loaded over a pending result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |=> (result_valid && state_q == STATE_RESET))
		else $error("terminator did not produce a result and restart");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && emit && !out_free) |=> ($stable(state_q) && valid_s1))
		else $error("parser state moved while its terminator was blocked");
`endif

endmodule

// ===== tb/tb_time_interval_text_parser.sv =====
`timescale 1ns / 1ps

module tb_time_interval_text_parser;
	import titp_pkg::*;

	localparam int RandomBytes = 1310;
	localparam int CycleLimit = 200000;
	localparam int DirRows = 18;

	localparam logic [7:0] NulByte = 8'h00;
	localparam logic [7:0] MinusByte = 8'h2D;
	localparam logic [31:0] MsecSecond = 32'd1000;
	localparam logic [31:0] MsecMinute = 32'd60000;
	localparam logic [31:0] MsecHour = 32'd3600000;
	localparam logic [31:0] MsecDay = 32'd86400000;
	localparam logic [31:0] MaxDays = 32'd24;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [7:0]  ch;
	logic        result_valid;
	logic        result_stall;
	logic        ok;
	logic [31:0] total_msecs;

	time_interval_text_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.ch           (ch),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ok           (ok),
		.total_msecs  (total_msecs)
	);

	// Unit words in priority order; the first surviving candidate wins.
	string unit_word [UnitCount] = '{
		"days", "hours", "minutes", "mins", "seconds", "secs",
		"milliseconds", "millisecs", "mseconds", "msecs"
	};

	string dir_text [DirRows] = '{
		"", "5", "24d", "25days", "4294967295ms", "4294967296", " \t1h 30MIN", "2 h",
		"3xyz5", "3xyz", "7:-s", "1\2002", "abc", "1secs, 2msec; 3m", "99999999999d 5",
		"1MilliSecondsXYZW", "10s\177", "\377"
	};
	bit dir_typed [DirRows] = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1};
	result_t dir_expect [DirRows] = '{
		{1'b0, 32'd0}, {1'b1, 32'd5000}, {1'b1, 32'd2073600000}, {1'b0, 32'd0},
		{1'b1, 32'hFFFFFFFF}, {1'b0, 32'd0}, {1'b0, 32'd0}, {1'b0, 32'd0},
		{1'b0, 32'd0}, {1'b0, 32'd0}, {1'b0, 32'd0}, {1'b0, 32'd0},
		{1'b0, 32'd0}, {1'b0, 32'd0}, {1'b0, 32'd0}, {1'b0, 32'd0},
		{1'b0, 32'd0}, {1'b0, 32'd0}
	};

	// Parser state tracked alongside the block.
	phase_t      p_phase;
	logic [31:0] p_num;
	logic [31:0] p_sum;
	logic        p_units_ok;
	unit_mask_t  p_match;
	logic [3:0]  p_wlen;

	logic [7:0] draft [$];
	bit         row_typed [$];
	result_t    row_value [$];
	result_t    pending_results [$];

	int  errors = 0;
	int  strings_sent = 0;
	int  results_seen = 0;
	int  bytes_sent = 0;
	int  cycle_count = 0;
	bit  idle_mode = 1'b1;
	bit  calm = 1'b0;

	function automatic bit ws(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit letter(input logic [7:0] c);
		return (c | 8'h20) >= "a" && (c | 8'h20) <= "z";
	endfunction

	function automatic bit mark(input logic [7:0] c);
		return c >= 8'd33 && c <= 8'd126 && !dig(c) && !letter(c);
	endfunction

	function automatic void parser_clear();
		p_phase = PH_LEAD;
		p_num = '0;
		p_sum = '0;
		p_units_ok = 1'b1;
		p_match = '1;
		p_wlen = '0;
	endfunction

	// Adds the finished unit word to the sum; returns 0 when the day count is too big.
	function automatic bit add_unit();
		int hit;
		hit = -1;
		for (int k = UnitCount - 1; k >= 0; k--) begin
			if (p_match[k]) hit = k;
		end
		if (hit < 0) begin
			p_units_ok = 1'b0;
			return 1'b1;
		end
		case (hit)
			0: begin
				if (p_num > MaxDays) return 1'b0;
				p_sum = p_sum + p_num * MsecDay;
			end
			1: p_sum = p_sum + p_num * MsecHour;
			2, 3: p_sum = p_sum + p_num * MsecMinute;
			4, 5: p_sum = p_sum + p_num * MsecSecond;
			default: p_sum = p_sum + p_num;
		endcase
		return 1'b1;
	endfunction

	// One byte through the parser; returns 1 when the byte ends a string and fills r.
	function automatic bit parse_step(input logic [7:0] c, output result_t r);
		logic [35:0] wide;
		logic [7:0]  lc;
		r = '0;
		if (p_phase == PH_LEAD) begin
			if (ws(c)) return 1'b0;
			if (dig(c)) begin
				p_num = 32'(c - "0");
				p_phase = PH_NUM;
				return 1'b0;
			end
			p_phase = PH_FAIL;
		end
		if (p_phase == PH_NUM) begin
			if (dig(c)) begin
				wide = {4'd0, p_num} * 36'd10 + 36'(c - "0");
				if (wide > 36'hFFFFFFFF) p_phase = PH_FAIL;
				else p_num = wide[31:0];
				return 1'b0;
			end
			p_phase = PH_PUNCT1;
		end
		if (p_phase == PH_PUNCT1) begin
			if (mark(c) && c != MinusByte) return 1'b0;
			p_wlen = '0;
			p_match = '1;
			p_phase = letter(c) ? PH_WORD : PH_SPACE1;
		end
		if (p_phase == PH_WORD) begin
			if (letter(c)) begin
				lc = c | 8'h20;
				for (int k = 0; k < UnitCount; k++) begin
					if (p_wlen >= unit_word[k].len() || unit_word[k][p_wlen] != lc)
						p_match[k] = 1'b0;
				end
				if (p_wlen < 4'd15) p_wlen = p_wlen + 4'd1;
				return 1'b0;
			end
			p_phase = add_unit() ? PH_SPACE1 : PH_FAIL;
		end
		if (p_phase == PH_SPACE1) begin
			if (ws(c)) return 1'b0;
			if (p_wlen == 4'd0) begin
				if (c == NulByte) begin
					// A bare trailing number counts as seconds and always succeeds.
					r.ok = 1'b1;
					r.total_msecs = p_sum + p_num * MsecSecond;
					parser_clear();
					return 1'b1;
				end
				p_phase = PH_FAIL;
			end else begin
				p_phase = PH_PUNCT2;
			end
		end
		if (p_phase == PH_PUNCT2) begin
			if (c == NulByte) begin
				r.ok = p_units_ok;
				r.total_msecs = p_sum;
				parser_clear();
				return 1'b1;
			end
			if (mark(c) && c != MinusByte) return 1'b0;
			if (dig(c)) begin
				p_num = 32'(c - "0");
				p_phase = PH_NUM;
				return 1'b0;
			end
			p_phase = PH_FAIL;
		end
		if (c == NulByte) begin
			r.ok = 1'b0;
			r.total_msecs = p_sum;
			parser_clear();
			return 1'b1;
		end
		p_phase = PH_FAIL;
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [7:0] rand_case(input logic [7:0] c);
		return $urandom_range(0, 1) ? (c & 8'hDF) : c;
	endfunction

	function automatic void push_space();
		draft.push_back($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
	endfunction

	function automatic void push_mark();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		while (!mark(c) || c == MinusByte) c = 8'($urandom_range(33, 126));
		draft.push_back(c);
	endfunction

	function automatic void push_number();
		logic [31:0] v;
		string s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = $urandom_range(0, 99);
			6: v = $urandom_range(0, 30);
			7: v = $urandom;
			8: v = 32'hFFFFFFFF - $urandom_range(0, 9);
			default: v = $urandom_range(0, 9);
		endcase
		if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) draft.push_back("0");
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
		// An extra digit on a big value pushes it past 32 bits.
		if ($urandom_range(0, 19) == 0) draft.push_back(8'("0" + $urandom_range(0, 9)));
	endfunction

	function automatic void push_word();
		int k;
		int pick;
		int n;
		pick = $urandom_range(0, 19);
		k = $urandom_range(0, UnitCount - 1);
		n = $urandom_range(1, unit_word[k].len());
		if (pick == 0) begin
			repeat ($urandom_range(1, 5)) draft.push_back(rand_case(8'("a" + $urandom_range(0, 25))));
		end else begin
			for (int i = 0; i < n; i++)
				draft.push_back(rand_case(unit_word[k][i]));
			if (pick == 1)
				repeat ($urandom_range(1, 6)) draft.push_back(rand_case(8'("a" + $urandom_range(0, 25))));
		end
	endfunction

	// Sends the drafted string plus its terminator, one transaction per byte.
	task automatic send_string(input bit typed, input result_t value);
		row_typed.push_back(typed);
		row_value.push_back(value);
		strings_sent++;
		draft.push_back(NulByte);
		for (int i = 0; i < draft.size(); i++) begin
			if (!calm && idle_mode && $urandom_range(0, 3) == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			item_valid <= 1'b1;
			ch <= draft[i];
			@(posedge clk);
			while (item_stall) @(posedge clk);
			bytes_sent++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 128 == 0) idle_mode = ($urandom_range(0, 2) != 0);
		if (cycle_count > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver back-pressure in random bursts.
	initial begin
		int burst;
		burst = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (calm) begin
				result_stall <= 1'b0;
			end else if (burst > 0) begin
				result_stall <= 1'b1;
				burst--;
			end else if (idle_mode && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 7) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Input monitor: every accepted byte goes through the parser model.
	always @(posedge clk) begin
		result_t r;
		result_t typed_value;
		bit      typed;
		if (arst_n && item_valid && !item_stall) begin
			if (parse_step(ch, r)) begin
				typed = row_typed.pop_front();
				typed_value = row_value.pop_front();
				pending_results.push_back(typed ? typed_value : r);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected transaction ok=%0b total_msecs=%0d",
					ok, total_msecs));
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok)
					flag_mismatch($sformatf("ok got %0b want %0b", ok, want.ok));
				if (total_msecs !== want.total_msecs)
					flag_mismatch($sformatf("total_msecs got %0d want %0d",
						total_msecs, want.total_msecs));
			end
		end
	end

	initial begin
		int start;
		int style;
		int terms;
		int pos;
		logic [7:0] b;
		arst_n = 1'b0;
		item_valid = 1'b0;
		ch = 8'h00;
		parser_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirRows; i++) begin
			draft.delete();
			for (int j = 0; j < dir_text[i].len(); j++) draft.push_back(dir_text[i][j]);
			send_string(dir_typed[i], dir_expect[i]);
		end

		// Drain everything before the random part starts.
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != strings_sent) @(posedge clk);

		start = bytes_sent;
		while (bytes_sent - start < RandomBytes) begin
			if (bytes_sent - start > RandomBytes * 85 / 100) calm = 1'b1;
			draft.delete();
			style = $urandom_range(0, 19);
			if (style < 2) begin
				repeat ($urandom_range(0, 10)) draft.push_back(8'($urandom_range(1, 255)));
			end else begin
				if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_space();
				terms = $urandom_range(1, 4);
				for (int t = 0; t < terms; t++) begin
					push_number();
					if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) push_mark();
					push_word();
					repeat ($urandom_range(0, 2)) push_space();
					if (t < terms - 1 && $urandom_range(0, 4) == 0) push_mark();
				end
				if ($urandom_range(0, 3) == 0) begin
					push_number();
					if ($urandom_range(0, 2) == 0) push_space();
				end
				// A few strings get one byte corrupted or inserted.
				if (style < 4) begin
					pos = $urandom_range(0, draft.size() - 1);
					case ($urandom_range(0, 2))
						0: b = 8'($urandom_range(1, 255));
						1: b = MinusByte;
						default: b = 8'd32;
					endcase
					if ($urandom_range(0, 1)) draft.insert(pos, b);
					else draft[pos] = b;
				end
			end
			send_string(1'b0, '0);
		end
		item_valid <= 1'b0;

		while (results_seen != strings_sent) @(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== time_interval_text_parser.f =====
sv/titp_pkg.sv
sv/titp_step.sv
sv/titp_out_reg.sv
sv/time_interval_text_parser.sv
tb/tb_time_interval_text_parser.sv
